### hdl/fir_filter_loadable_coefficients_unit_defines.svh
// Assertion macros for the filter RTL.
// Depends on nothing; included by the top-level filter module, which checks its own logic.
`ifndef FIR_FILTER_LOADABLE_COEFFICIENTS_UNIT_DEFINES_SVH
`define FIR_FILTER_LOADABLE_COEFFICIENTS_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define FFLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fflc check failed");
`define FFLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fflc check failed");
`else
`define FFLC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FFLC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/fflc_pkg.sv
// Shared types and constants for the loadable-coefficient FIR filter.
// No dependencies.
`default_nettype none
package fflc_pkg;

  localparam int TAP_IDX_BITS = 5;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_COEF   = 1'b1
  } req_type_t;

  // Per-cycle command broadcast to every tap cell.
  typedef struct packed {
    logic shift;   // advance the delay line, insert new sample
    logic rotate;  // circulate sample and coefficient one place toward cell 0
    logic load;    // write coefficient into the selected cell
  } cell_ctrl_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic mul_en;  // multiply the head-cell pair this cycle
  } mac_ctrl_t;

endpackage
`default_nettype wire

### hdl/fflc_cell.sv
// One tap cell: holds a sample and a coefficient, passes both to its neighbors.
// Depends on fflc_pkg.
`default_nettype none
module fflc_cell #(
  parameter int W = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire fflc_pkg::cell_ctrl_t ctrl,
  input  wire logic                wr_sel,
  input  wire logic signed [W-1:0] wr_coef,
  input  wire logic signed [W-1:0] shift_in,
  input  wire logic signed [W-1:0] rot_sample_in,
  input  wire logic signed [W-1:0] rot_coef_in,
  output logic signed [W-1:0]      sample_o,
  output logic signed [W-1:0]      coef_o
);

  logic signed [W-1:0] sample_r;
  logic signed [W-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      coef_r   <= '0;
    end else begin
      if (ctrl.shift) begin
        sample_r <= shift_in;
      end else if (ctrl.rotate) begin
        sample_r <= rot_sample_in;
      end
      if (ctrl.load && wr_sel) begin
        coef_r <= wr_coef;
      end else if (ctrl.rotate) begin
        coef_r <= rot_coef_in;
      end
    end
  end

  assign sample_o = sample_r;
  assign coef_o   = coef_r;

endmodule
`default_nettype wire

### hdl/fflc_mac.sv
// Shared multiply-accumulate: registered product, wrapping accumulator.
// Depends on fflc_pkg.
`default_nettype none
module fflc_mac #(
  parameter int W = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fflc_pkg::mac_ctrl_t  ctrl,
  input  wire logic signed [W-1:0]  sample_i,
  input  wire logic signed [W-1:0]  coef_i,
  output logic signed [2*W-1:0]     sum_o
);

  logic signed [2*W-1:0] product_r;
  logic signed [2*W-1:0] product_nxt;
  logic signed [2*W-1:0] acc_r;
  logic                  prod_vld_r;

  assign product_nxt = sample_i * coef_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      acc_r      <= '0;
    end else begin
      prod_vld_r <= ctrl.mul_en;
      if (ctrl.clear) begin
        acc_r <= '0;
      end else if (prod_vld_r) begin
        acc_r <= acc_r + product_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      product_r <= product_nxt;
    end
  end

  // Fold in the last product until the accumulator has taken it.
  assign sum_o = prod_vld_r ? (acc_r + product_r) : acc_r;

endmodule
`default_nettype wire

### hdl/fir_filter_loadable_coefficients_unit.sv
// Direct-form FIR filter, TAP_COUNT taps, loadable Q15 coefficients.
// The result enters the output register from the writeback state, after the ring has turned once.
// A new sample waits until the last one is written back, the single shared multiplier
//   walking the ring of tap cells meanwhile; coefficient beats 1/cycle while idle.
//   A result still held downstream delays the next sample's writeback.
// Reset (rst_n low, synchronous) zeroes the delay line and every coefficient.
`default_nettype none
`include "fir_filter_loadable_coefficients_unit_defines.svh"
module fir_filter_loadable_coefficients_unit #(
  parameter int TAP_COUNT   = 23,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 in_req_type,
  input  wire logic [fflc_pkg::TAP_IDX_BITS-1:0]    in_tap_index,
  input  wire logic signed [SAMPLE_BITS-1:0]        in_value,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [SAMPLE_BITS-1:0]             out_filtered_sample
);

  localparam int CNT_W = $clog2(TAP_COUNT);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WB
  } state_t;

  state_t                         state_r;
  logic [CNT_W-1:0]               cnt_r;
  logic                           out_valid_r;
  logic signed [SAMPLE_BITS-1:0]  out_sample_r;

  logic                           in_fire;
  logic                           is_coef;
  logic                           wb_fire;
  fflc_pkg::cell_ctrl_t           cell_ctrl;
  fflc_pkg::mac_ctrl_t            mac_ctrl;
  logic signed [SAMPLE_BITS-1:0]  cell_sample [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0]  cell_coef   [TAP_COUNT];
  logic signed [2*SAMPLE_BITS-1:0] mac_sum;

  // Take beats only when idle; a pending result in the output register
  // does not block new beats.
  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign is_coef  = (in_req_type == fflc_pkg::REQ_COEF);

  // Write back once the output register is empty or drains this cycle.
  assign wb_fire = (state_r == ST_WB) && (!out_valid_r || !out_stall);

  // A sample shifts the line at accept; the ring then rotates TAP_COUNT
  // times, bringing every cell past cell 0 and back to its own place.
  assign cell_ctrl.shift  = in_fire && !is_coef;
  assign cell_ctrl.load   = in_fire && is_coef;
  assign cell_ctrl.rotate = (state_r == ST_RUN);

  assign mac_ctrl.clear  = cell_ctrl.shift;
  assign mac_ctrl.mul_en = (state_r == ST_RUN);

  for (genvar i = 0; i < TAP_COUNT; i++) begin : g_cell
    localparam int NEXT = (i + 1) % TAP_COUNT;
    logic                          sel;
    logic signed [SAMPLE_BITS-1:0] shift_src;

    // Out-of-range tap indexes select no cell and are dropped.
    assign sel = (32'(in_tap_index) == i);

    if (i == 0) begin : g_head
      assign shift_src = in_value;
    end else begin : g_body
      assign shift_src = cell_sample[i-1];
    end

    fflc_cell #(
      .W (SAMPLE_BITS)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .ctrl          (cell_ctrl),
      .wr_sel        (sel),
      .wr_coef       (in_value),
      .shift_in      (shift_src),
      .rot_sample_in (cell_sample[NEXT]),
      .rot_coef_in   (cell_coef[NEXT]),
      .sample_o      (cell_sample[i]),
      .coef_o        (cell_coef[i])
    );
  end

  fflc_mac #(
    .W (SAMPLE_BITS)
  ) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mac_ctrl),
    .sample_i (cell_sample[0]),
    .coef_i   (cell_coef[0]),
    .sum_o    (mac_sum)
  );

  // Sequencer plus output register. The result is bits [2W-2:W-1] of the
  // wrapped sum: arithmetic shift by W-1, then keep the low W bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (wb_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (cell_ctrl.shift) begin
            state_r <= ST_RUN;
            cnt_r   <= '0;
          end
        end
        ST_RUN: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(TAP_COUNT - 1)) begin
            state_r <= ST_WB;
          end
        end
        ST_WB: begin
          // Hold here while the previous beat still waits downstream.
          if (wb_fire) begin
            out_sample_r <= mac_sum[2*SAMPLE_BITS-2:SAMPLE_BITS-1];
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_filtered_sample = out_sample_r;

  `FFLC_ASSERT_NEXT(a_sample_busy, clk, rst_n, cell_ctrl.shift, in_stall)
  `FFLC_ASSERT_NEXT(a_coef_nobusy, clk, rst_n, cell_ctrl.load, !in_stall)
  `FFLC_ASSERT_SAME(a_result_src, clk, rst_n, $rose(out_valid), $past(state_r == ST_WB))
  `FFLC_ASSERT_SAME(a_cnt_range, clk, rst_n, state_r == ST_RUN, cnt_r <= CNT_W'(TAP_COUNT - 1))

endmodule
`default_nettype wire

### verif/fir_output_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the loadable-coefficient FIR filter: predicts each filtered sample.
// Depends on fflc_pkg for the request codes.
module fir_output_checker
  import fflc_pkg::*;
#(
  parameter int TAP_COUNT   = 23,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [TAP_IDX_BITS-1:0]       in_tap_index,
  input  logic signed [SAMPLE_BITS-1:0] in_value,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_filtered_sample,
  output int                            outstanding,
  output int                            mismatches
);

  logic signed [SAMPLE_BITS-1:0] delay_line [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0] coefs [TAP_COUNT];
  logic signed [SAMPLE_BITS-1:0] expected_outputs [$];
  int                            error_total = 0;

  initial begin
    outstanding = 0;
    mismatches  = 0;
  end

  // Sum of products in a wrapping double-width accumulator, scaled back by Q15.
  function automatic logic signed [SAMPLE_BITS-1:0] filter_response();
    logic signed [2*SAMPLE_BITS-1:0] acc;
    logic signed [2*SAMPLE_BITS-1:0] scaled;
    acc = '0;
    for (int k = 0; k < TAP_COUNT; k++) acc = acc + delay_line[k] * coefs[k];
    scaled = acc >>> (SAMPLE_BITS - 1);
    return scaled[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk) begin
    logic signed [SAMPLE_BITS-1:0] want;
    if (!rst_n) begin
      for (int k = 0; k < TAP_COUNT; k++) begin
        delay_line[k] = '0;
        coefs[k]      = '0;
      end
      expected_outputs.delete();
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_outputs.size() == 0) begin
          error_total++;
          $display("%0t: unexpected filtered_sample beat, got %0d", $time,
                   out_filtered_sample);
        end else begin
          want = expected_outputs.pop_front();
          if (out_filtered_sample !== want) begin
            error_total++;
            $display("%0t: filtered_sample mismatch, expected %0d, got %0d", $time,
                     want, out_filtered_sample);
          end
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        if (req_type_t'(in_req_type) == REQ_COEF) begin
          // writes past the last tap leave the block untouched
          if (in_tap_index < TAP_COUNT) coefs[in_tap_index] = in_value;
        end else begin
          for (int k = TAP_COUNT - 1; k > 0; k--) delay_line[k] = delay_line[k-1];
          delay_line[0] = in_value;
          expected_outputs.push_back(filter_response());
        end
      end
    end
    outstanding <= expected_outputs.size();
    mismatches  <= error_total;
  end

endmodule

### verif/tb_fir_filter_loadable_coefficients_unit.sv
`timescale 1ns / 1ps
// Top-level testbench for fir_filter_loadable_coefficients_unit: stimulus and verdict.
// Depends on fflc_pkg, the filter RTL and fir_output_checker.
module tb_fir_filter_loadable_coefficients_unit;
  import fflc_pkg::*;

  localparam int TAP_COUNT    = 23;
  localparam int SAMPLE_BITS  = 16;
  localparam int ITEM_TARGET  = 1650;
  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 40;   // longer than the sample latency

  localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_BITS-1:0] VAL_NEG = 16'shFFFF;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_req_type = REQ_SAMPLE;
  logic [TAP_IDX_BITS-1:0]       in_tap_index = '0;
  logic signed [SAMPLE_BITS-1:0] in_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_filtered_sample;

  int outstanding;
  int mismatches;
  int cycle_count = 0;

  // calm: no idling on either side; hold_off_req: ask the receiver for a long stall
  bit calm = 1'b0;
  bit hold_off_req = 1'b0;

  always #2 clk = ~clk;

  fir_filter_loadable_coefficients_unit #(
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_tap_index       (in_tap_index),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_sample(out_filtered_sample)
  );

  fir_output_checker #(
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_tap_index       (in_tap_index),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_filtered_sample(out_filtered_sample),
    .outstanding        (outstanding),
    .mismatches         (mismatches)
  );

  // Guard against a hung block: fail once the cycle budget runs out.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("** fir_filter_loadable_coefficients_unit: FAILED **");
      $finish;
    end
  end

  // Receiver: stall about a quarter of the cycles, or hold off for a long
  // stretch on request so the filter backs up into its input.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 26);
      end
    end
  end

  // Random words half the time, else edge values; only the nonzero edge values on request.
  function automatic logic signed [SAMPLE_BITS-1:0] pick_value(input bit only_extremes);
    case (only_extremes ? $urandom_range(0, 3) : $urandom_range(0, 9))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_NEG;
      3:       return 16'sd1;
      4:       return '0;
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // Offer one beat, maybe after idling at random; return once it is taken.
  task automatic send_item(input req_type_t kind, input logic [TAP_IDX_BITS-1:0] idx,
                           input logic signed [SAMPLE_BITS-1:0] val);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_tap_index <= idx;
    in_value     <= val;
    do @(posedge clk); while (in_stall);
  endtask

  // Drop valid and wait until every predicted sample has come out.
  // The extra edge lets the checker's count catch up with the last beat.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    int  items_sent;
    int  burst;
    int  roll;
    bit  held;
    bit  drained;
    logic [TAP_IDX_BITS-1:0] idx;

    items_sent = 0;
    held       = 1'b0;
    drained    = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. All coefficients are zero after reset, so the first
    // sample must come out as zero.
    send_item(REQ_SAMPLE, 5'd31, 16'sd100);
    send_item(REQ_COEF,   5'd0,  VAL_MAX);
    send_item(REQ_SAMPLE, 5'd0,  VAL_MAX);
    send_item(REQ_SAMPLE, 5'd0,  VAL_MIN);
    // Full-scale negative squared: the scaled sum no longer fits and gets truncated.
    send_item(REQ_COEF,   5'd0,  VAL_MIN);
    send_item(REQ_SAMPLE, 5'd0,  VAL_MIN);
    // Two such products wrap the accumulator.
    send_item(REQ_COEF,   5'd1,  VAL_MIN);
    send_item(REQ_SAMPLE, 5'd0,  VAL_MIN);
    // Writes past the last tap must be dropped.
    send_item(REQ_COEF,   5'd23, 16'sd12345);
    send_item(REQ_COEF,   5'd31, VAL_NEG);
    send_item(REQ_SAMPLE, 5'd0,  '0);
    send_item(REQ_COEF,   5'd22, 16'sd1);
    send_item(REQ_COEF,   5'd11, VAL_NEG);
    send_item(REQ_COEF,   5'd21, VAL_MAX);
    send_item(REQ_SAMPLE, 5'd31, 16'sd1);
    send_item(REQ_SAMPLE, 5'd10, VAL_NEG);
    send_item(REQ_SAMPLE, 5'd21, VAL_MAX);
    send_item(REQ_SAMPLE, 5'd0,  VAL_MIN);
    send_item(REQ_SAMPLE, 5'd31, 16'sd12345);
    send_item(REQ_SAMPLE, 5'd5,  -16'sd12345);

    // Random part: coefficient reloads, occasional edge-value loads of every tap and
    // bursts of samples.
    while (items_sent < ITEM_TARGET) begin
      if (!held && items_sent >= 300) begin
        held         = 1'b1;
        hold_off_req = 1'b1;
      end
      if (!drained && items_sent >= 800) begin
        drained = 1'b1;
        wait_for_drain();
      end
      calm = (items_sent >= 1000 && items_sent < 1250);

      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        burst = $urandom_range(1, 6);
        repeat (burst) begin
          if ($urandom_range(0, 19) == 0) begin
            idx = TAP_IDX_BITS'($urandom_range(TAP_COUNT, 31));
          end else begin
            idx = TAP_IDX_BITS'($urandom_range(0, TAP_COUNT - 1));
            items_sent++;
          end
          send_item(REQ_COEF, idx, pick_value(1'b0));
        end
      end else if (roll < 40) begin
        // edge-value weights (min, max, -1 or 1) on every tap can push the sum into overflow
        for (int k = 0; k < TAP_COUNT; k++) begin
          send_item(REQ_COEF, TAP_IDX_BITS'(k), pick_value(1'b1));
          items_sent++;
        end
      end else begin
        burst = $urandom_range(1, 10);
        repeat (burst) begin
          send_item(REQ_SAMPLE, TAP_IDX_BITS'($urandom_range(0, 31)), pick_value(1'b0));
          items_sent++;
        end
      end
    end
    calm = 1'b0;

    wait_for_drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("** fir_filter_loadable_coefficients_unit: PASSED **");
    end else begin
      $display("** fir_filter_loadable_coefficients_unit: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/fflc_pkg.sv
hdl/fflc_cell.sv
hdl/fflc_mac.sv
hdl/fir_filter_loadable_coefficients_unit.sv
verif/fir_output_checker.sv
verif/tb_fir_filter_loadable_coefficients_unit.sv
